@@ design/ssbd_pkg.sv @@
// Shared types and constants for the start/stop byte deframer.
// No dependencies; imported by the controller, datapath and top level.
package ssbd_pkg;

   localparam int BYTE_W                = 8;
   localparam int PAYLOAD_BYTES_DEFAULT = 8;
   localparam int CSR_INDEX_W           = 1;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] STOP_MARKER_RESET  = 8'h55;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_MARKER  = 1'b1;

   // controller -> datapath commands
   typedef struct packed {
      logic fill_clear;    // restart payload fill at entry zero
      logic fill_write;    // store the accepted word and advance the fill index
      logic emit_load;     // fetch the first stored word into the output register
      logic emit_advance;  // fetch the next stored word into the output register
   } ssbd_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic start_hit;     // incoming word equals the start marker
      logic stop_hit;      // incoming word equals the stop marker
      logic fill_last;     // fill index sits on the last payload entry
      logic emit_last;     // output register holds the last payload word
   } ssbd_sts_type;

endpackage

@@ design/start_stop_byte_deframer.sv @@
// Start/stop byte deframer with a fixed payload length.
// Channels: req_* carries received serial bytes (one word per handshake);
//   rsp_* carries the payload of each accepted frame, one word per
//   handshake, in received order, with rsp_payload_last on the final word.
// A frame is the start marker, PAYLOAD_BYTES payload words (markers inside
//   are plain data) and one check word. If the check word equals the stop
//   marker the payload is emitted; otherwise the frame is dropped silently
//   and the check word is never taken as a new start.
// csr_*: write csr_index 0 for the start marker, 1 for the stop marker;
//   write only while the block is idle. Reset values 0xAA and 0x55.
// Throughput: one input word per cycle while parsing. After the stop word is
//   accepted the first payload word is valid on the next cycle, then one word
//   per cycle while rsp_ready is high; the payload buffer has a registered read
//   port. req_ready stays low while the payload goes out, until the last
//   payload word is taken.
// Receiver stall: rsp_ready low holds the current word and last flag.
// Reset (synchronous, active high): parser returns to waiting for start,
//   markers return to their reset values, nothing is output. The buffer is
//   not cleared; every entry is written before it is read.
// Depends on ssbd_pkg, ssbd_ctrl and ssbd_dpath.
module start_stop_byte_deframer #(
   parameter int PAYLOAD_BYTES = ssbd_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // received bytes
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssbd_pkg::BYTE_W-1:0]       req_rx_byte,
   // payload out
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssbd_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic                              rsp_payload_last,
   // configuration writes
   input  logic                              csr_we,
   input  logic [ssbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssbd_pkg::BYTE_W-1:0]       csr_wdata
);
   import ssbd_pkg::*;

   ssbd_cmd_type cmd;
   ssbd_sts_type sts;

   // parser: decides when to store, check and emit
   ssbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // buffer, markers and output register
   ssbd_dpath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_rx_byte      (req_rx_byte),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

@@ design/ssbd_dpath.sv @@
// Datapath of the deframer: marker registers, payload buffer, fill and read
// indexes and the output register. Depends on ssbd_pkg.
module ssbd_dpath #(
   parameter int PAYLOAD_BYTES = ssbd_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssbd_pkg::ssbd_cmd_type              cmd,
   output ssbd_pkg::ssbd_sts_type              sts,
   input  logic [ssbd_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic [ssbd_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic                                rsp_payload_last,
   input  logic                                csr_we,
   input  logic [ssbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssbd_pkg::BYTE_W-1:0]         csr_wdata
);
   import ssbd_pkg::*;

   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

   logic [BYTE_W-1:0] start_marker_ff, start_marker_in;
   logic [BYTE_W-1:0] stop_marker_ff, stop_marker_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              last_ff, last_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] payload_mem_ff [PAYLOAD_BYTES];
   logic [IDX_W-1:0]  rd_addr;
   logic              rd_en;

   // csr decode
   always_comb begin
      start_marker_in = start_marker_ff;
      stop_marker_in  = stop_marker_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_wdata;
            CSR_STOP_MARKER:  stop_marker_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rd_en   = cmd.emit_load | cmd.emit_advance;
   assign rd_addr = cmd.emit_load ? '0 : rd_idx_ff + 1'b1;

   always_comb begin
      fill_in   = fill_ff;
      rd_idx_in = rd_idx_ff;
      last_in   = last_ff;
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.fill_write) begin
         fill_in = fill_ff + 1'b1;
      end
      if (rd_en) begin
         rd_idx_in = rd_addr;
         last_in   = (rd_addr == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         stop_marker_ff  <= STOP_MARKER_RESET;
         fill_ff         <= '0;
         rd_idx_ff       <= '0;
         last_ff         <= 1'b0;
      end else begin
         start_marker_ff <= start_marker_in;
         stop_marker_ff  <= stop_marker_in;
         fill_ff         <= fill_in;
         rd_idx_ff       <= rd_idx_in;
         last_ff         <= last_in;
      end
   end

   // payload buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.fill_write) begin
         payload_mem_ff[fill_ff] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= payload_mem_ff[rd_addr];
      end
   end

   assign sts.start_hit = (req_rx_byte == start_marker_ff);
   assign sts.stop_hit  = (req_rx_byte == stop_marker_ff);
   assign sts.fill_last = (fill_ff == LAST_IDX);
   assign sts.emit_last = last_ff;

   assign rsp_payload_byte = rd_data_ff;
   assign rsp_payload_last = last_ff;

   // never step the read index past the last entry
   a_no_advance_past_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_advance |-> !last_ff)
      else $error("emit advance while last payload word is out");

   // a fill restart and a store never coincide
   a_fill_cmds_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_clear && cmd.fill_write))
      else $error("fill clear and fill write together");

   // the read index lands on the last entry exactly when last is flagged
   a_last_matches_index: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (last_ff == (rd_idx_ff == LAST_IDX)))
      else $error("last flag disagrees with read index");

endmodule

@@ design/ssbd_ctrl.sv @@
// Frame parser state machine of the deframer: sequences the datapath over
// wait-for-start, payload fill, stop check and payload emit. Depends on ssbd_pkg.
module ssbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ssbd_pkg::ssbd_sts_type  sts,
   output ssbd_pkg::ssbd_cmd_type  cmd
);
   import ssbd_pkg::*;

   localparam logic [1:0] ST_WAIT_START = 2'd0;
   localparam logic [1:0] ST_READ       = 2'd1;
   localparam logic [1:0] ST_WAIT_STOP  = 2'd2;
   localparam logic [1:0] ST_EMIT       = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       req_fire;

   assign req_ready = (state_ff != ST_EMIT);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_WAIT_START: begin
            if (req_fire && sts.start_hit) begin
               cmd.fill_clear = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            if (req_fire) begin
               cmd.fill_write = 1'b1;
               if (sts.fill_last) begin
                  state_in = ST_WAIT_STOP;
               end
            end
         end
         ST_WAIT_STOP: begin
            if (req_fire) begin
               if (sts.stop_hit) begin
                  cmd.emit_load = 1'b1;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_WAIT_START;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (sts.emit_last) begin
                  state_in = ST_WAIT_START;
               end else begin
                  cmd.emit_advance = 1'b1;
               end
            end
         end
         default: state_in = ST_WAIT_START;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT_START;
      end else begin
         state_ff <= state_in;
      end
   end

   // input side stays closed while a payload is going out
   a_no_input_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open while emitting");

   // the last payload word handed over reopens the input side
   a_reopen_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sts.emit_last) |=> (req_ready && !rsp_valid))
      else $error("input not reopened after last word");

   // nothing goes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ tb/start_stop_byte_deframer_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for start_stop_byte_deframer: queue-fed driver, clocked
// monitor and an in-bench frame predictor checking every payload word.
// Depends on ssbd_pkg and the start_stop_byte_deframer RTL only.
module start_stop_byte_deframer_test;
   import ssbd_pkg::*;

   localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT;
   // cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT   = 4000;
   // settling time given to the emit path after the payload queue drains
   localparam int SETTLE_CYCLES = PAYLOAD_BYTES + 4;
   localparam int RANDOM_BYTES  = 100;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef enum logic [1:0] {AWAIT_START, COLLECT, AWAIT_STOP} parse_phase_type;
   typedef struct packed {
      byte_type data;
      logic     last;
   } payload_word_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   byte_type               req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   byte_type               rsp_payload_byte;
   logic                   rsp_payload_last;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_START_MARKER;
   byte_type               csr_wdata   = '0;

   // received bytes waiting to be driven, and payload words still owed by the block
   byte_type         rx_pending[$];
   payload_word_type payload_due[$];
   logic             req_fire = 1'b0;

   // idle odds in percent for each side
   int send_idle_pct = 10;
   int recv_idle_pct = 76;

   // frame predictor state
   byte_type        start_marker_m = START_MARKER_RESET;
   byte_type        stop_marker_m  = STOP_MARKER_RESET;
   parse_phase_type phase_m        = AWAIT_START;
   int              fill_m         = 0;
   byte_type        store_m[PAYLOAD_BYTES];

   int bytes_in       = 0;
   int words_out      = 0;
   int frames_ok      = 0;
   int frames_dropped = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;

   always #5 clock = ~clock;

   start_stop_byte_deframer #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_last(rsp_payload_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Advance the parser by one received byte and queue any payload it releases.
   task automatic deframe_byte(input byte_type b);
      case (phase_m)
         COLLECT: begin
            store_m[fill_m] = b;
            fill_m++;
            if (fill_m >= PAYLOAD_BYTES) phase_m = AWAIT_STOP;
         end
         AWAIT_STOP: begin
            // the check byte is consumed here, never reused as a start
            if (b == stop_marker_m) begin
               for (int k = 0; k < PAYLOAD_BYTES; k++)
                  payload_due.push_back('{data: store_m[k], last: (k == PAYLOAD_BYTES - 1)});
               frames_ok++;
            end else begin
               frames_dropped++;
            end
            phase_m = AWAIT_START;
         end
         default: begin
            phase_m = AWAIT_START;
            if (b == start_marker_m) begin
               fill_m  = 0;
               phase_m = COLLECT;
            end
         end
      endcase
   endtask

   // Queue mostly whole frames with random content, plus short bursts of noise.
   task automatic queue_random_traffic(input int n);
      int       added;
      byte_type b;
      added = 0;
      while (added < n) begin
         if ($urandom_range(99) < 80) begin
            rx_pending.push_back(start_marker_m);
            // sprinkle marker values into the payload; they must pass as data
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
               case ($urandom_range(9))
                  0:       b = start_marker_m;
                  1:       b = stop_marker_m;
                  default: b = byte_type'($urandom);
               endcase
               rx_pending.push_back(b);
            end
            // close mostly with the stop marker; otherwise break the frame,
            // sometimes with a start marker that must not reopen it
            case ($urandom_range(9))
               0:       b = byte_type'($urandom);
               1:       b = start_marker_m;
               default: b = stop_marker_m;
            endcase
            rx_pending.push_back(b);
            added += PAYLOAD_BYTES + 2;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               rx_pending.push_back(byte_type'($urandom));
               added++;
            end
         end
      end
   endtask

   // Hold until every byte is taken and every payload word has come out,
   // then give the emit path time to show anything spurious.
   task automatic wait_idle();
      wait (rx_pending.size() == 0 && !req_valid);
      wait (payload_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_marker(input logic [CSR_INDEX_W-1:0] idx, input byte_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Driver: present the next byte at the falling edge; keep it until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (rx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: sample both channels and the register port at the rising edge.
   always @(posedge clock) begin
      payload_word_type due;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte);
            bytes_in++;
         end
         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (payload_due.size() == 0) begin
               $error("payload word %02h (last %0b) with no frame pending",
                      rsp_payload_byte, rsp_payload_last);
               fail_count++;
            end else begin
               due = payload_due.pop_front();
               if (rsp_payload_byte !== due.data) begin
                  $error("payload_byte: expected %02h, actual %02h",
                         due.data, rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_payload_last !== due.last) begin
                  $error("payload_last: expected %0b, actual %0b",
                         due.last, rsp_payload_last);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_START_MARKER) start_marker_m = csr_wdata;
            else if (csr_index == CSR_STOP_MARKER) stop_marker_m = csr_wdata;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // Watchdog: drop the run if neither channel moves for too long.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("** start_stop_byte_deframer: FAILED **");
      $finish;
   end

   initial begin
      byte_type directed_seq[23];
      byte_type shared_marker;

      // With reset markers: noise, a good frame carrying both markers and the
      // byte extremes as data, then a frame closed by a start marker (dropped,
      // and not reopened), then a stray stop marker while waiting for start.
      directed_seq = '{
         8'h00, 8'hFF,
         8'hAA, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55,
         8'hAA, 8'h11, 8'h22, 8'h33, 8'h44, 8'h5A, 8'h66, 8'h77, 8'h88, 8'hAA,
         8'h55
      };

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // sender idles rarely, receiver mostly stalls
      send_idle_pct = 10;
      recv_idle_pct = 76;
      foreach (directed_seq[i]) rx_pending.push_back(directed_seq[i]);
      queue_random_traffic(RANDOM_BYTES);
      wait_idle();

      // low/high marker extremes, with the idle odds swapped
      write_marker(CSR_START_MARKER, 8'h00);
      write_marker(CSR_STOP_MARKER, 8'hFF);
      send_idle_pct = 76;
      recv_idle_pct = 10;
      queue_random_traffic(RANDOM_BYTES);
      wait_idle();

      // reversed extremes at full rate
      write_marker(CSR_START_MARKER, 8'hFF);
      write_marker(CSR_STOP_MARKER, 8'h00);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_traffic(RANDOM_BYTES);
      wait_idle();

      // one value for both markers: the stop check must win over a new start
      shared_marker = byte_type'($urandom);
      write_marker(CSR_START_MARKER, shared_marker);
      write_marker(CSR_STOP_MARKER, shared_marker);
      queue_random_traffic(RANDOM_BYTES);
      wait_idle();

      $display("Run covered %0d received bytes under markers AA/55, 00/FF, FF/00 and %02h/%02h.",
               bytes_in, shared_marker, shared_marker);
      $display("%0d frames emitted, %0d dropped, %0d payload words checked, %0d mismatches.",
               frames_ok, frames_dropped, words_out, fail_count);
      if (fail_count == 0) begin
         $display("** start_stop_byte_deframer: PASSED **");
      end else begin
         $display("** start_stop_byte_deframer: FAILED **");
      end
      $finish;
   end

endmodule
